@@ design/bumq_pkg.sv @@
// Shared types, register indexes and reset constants for the BGR mean/quantize block.
package bumq_pkg;

   // Build frame size defaults
   localparam int BUMQ_BUILD_WIDTH  = 224;
   localparam int BUMQ_BUILD_HEIGHT = 224;
   localparam int BUMQ_QUEUE_DEPTH  = 4;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_FIX_POSITION = 3'd0;
   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd1;
   localparam logic [2:0] CSR_FRAME_HEIGHT = 3'd2;
   localparam logic [2:0] CSR_MEAN_BLUE    = 3'd3;
   localparam logic [2:0] CSR_MEAN_GREEN   = 3'd4;
   localparam logic [2:0] CSR_MEAN_RED     = 3'd5;

   // Register reset values
   localparam logic [3:0]  RST_FIX_POSITION = 4'd7;
   localparam logic [11:0] RST_FRAME_WIDTH  = 12'd224;
   localparam logic [11:0] RST_FRAME_HEIGHT = 12'd224;
   localparam logic [15:0] RST_MEAN_BLUE    = 16'd26608;
   localparam logic [15:0] RST_MEAN_GREEN   = 16'd29895;
   localparam logic [15:0] RST_MEAN_RED     = 16'd31662;

   typedef struct packed {
      logic [3:0]  fix_position;
      logic [11:0] frame_width;
      logic [11:0] frame_height;
      logic [15:0] mean_blue;
      logic [15:0] mean_green;
      logic [15:0] mean_red;
   } bumq_cfg_type;

   // One pixel job between front and back: raw bytes plus run/frame markers
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_in_run;
      logic       frame_end;
   } bumq_job_type;

endpackage

@@ design/bumq_front.sv @@
// Front end: accept packed words, carry leftover bytes, issue one pixel job per cycle while the queue takes them.
module bumq_front import bumq_pkg::*; #(
   parameter int BUILD_WIDTH  = BUMQ_BUILD_WIDTH,
   parameter int BUILD_HEIGHT = BUMQ_BUILD_HEIGHT
) (
   input  logic         clock,
   input  logic         reset,
   input  bumq_cfg_type cfg,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [63:0]  req_word,
   input  logic         req_frame_start,
   output logic         job_valid,
   input  logic         job_ready,
   output bumq_job_type job
);

   localparam int TOTAL = BUILD_WIDTH * BUILD_HEIGHT;
   localparam int CNT_W = $clog2(TOTAL + 1);
   localparam logic [CNT_W-1:0] TOTAL_C = CNT_W'(TOTAL);
   localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

   logic             busy_ff, busy_in;
   logic [71:0]      buf_ff, buf_in;
   logic [1:0]       npix_ff, npix_in;
   logic [1:0]       idx_ff, idx_in;
   logic [15:0]      carry_bytes_ff, carry_bytes_in;
   logic [1:0]       carry_count_ff, carry_count_in;
   logic [CNT_W-1:0] pixel_count_ff, pixel_count_in;

   logic             push, done, accept, size_ok, run;
   logic [CNT_W-1:0] cnt_cur, base_cnt;
   logic [15:0]      base_carry;
   logic [1:0]       base_carry_cnt;
   logic [23:0]      sel;

   always_comb begin
      size_ok = (cfg.frame_width == 12'(BUILD_WIDTH)) && (cfg.frame_height == 12'(BUILD_HEIGHT));

      case (idx_ff)
         2'd1:    sel = buf_ff[47:24];
         2'd2:    sel = buf_ff[71:48];
         default: sel = buf_ff[23:0];
      endcase

      job.blue        = sel[7:0];
      job.green       = sel[15:8];
      job.red         = sel[23:16];
      job.frame_end   = (pixel_count_ff == TOTAL_C - ONE_C);
      job.last_in_run = (idx_ff == npix_ff - 2'd1) || job.frame_end;
      job_valid       = busy_ff;

      push      = busy_ff && job_ready;
      done      = push && job.last_in_run;
      req_ready = !busy_ff || done;
      accept    = req_valid && req_ready;

      cnt_cur        = push ? pixel_count_ff + ONE_C : pixel_count_ff;
      base_cnt       = req_frame_start ? '0 : cnt_cur;
      base_carry     = req_frame_start ? '0 : carry_bytes_ff;
      base_carry_cnt = req_frame_start ? 2'd0 : carry_count_ff;
      run            = size_ok && (base_cnt < TOTAL_C);

      busy_in        = busy_ff;
      buf_in         = buf_ff;
      npix_in        = npix_ff;
      idx_in         = push ? idx_ff + 2'd1 : idx_ff;
      carry_bytes_in = carry_bytes_ff;
      carry_count_in = carry_count_ff;
      pixel_count_in = cnt_cur;

      if (done) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         // Frame start clears carry and count even when the word is dropped
         busy_in        = run;
         idx_in         = 2'd0;
         pixel_count_in = base_cnt;
         carry_bytes_in = base_carry;
         carry_count_in = base_carry_cnt;
         if (run) begin
            case (base_carry_cnt)
               2'd1: begin
                  buf_in         = {req_word, base_carry[7:0]};
                  npix_in        = 2'd3;
                  carry_count_in = 2'd0;
                  carry_bytes_in = 16'd0;
               end
               2'd2: begin
                  buf_in         = {req_word[55:0], base_carry};
                  npix_in        = 2'd3;
                  carry_count_in = 2'd1;
                  carry_bytes_in = {8'd0, req_word[63:56]};
               end
               default: begin
                  buf_in         = {8'd0, req_word};
                  npix_in        = 2'd2;
                  carry_count_in = 2'd2;
                  carry_bytes_in = req_word[63:48];
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         idx_ff         <= 2'd0;
         npix_ff        <= 2'd2;
         carry_bytes_ff <= 16'd0;
         carry_count_ff <= 2'd0;
         pixel_count_ff <= '0;
      end else begin
         busy_ff        <= busy_in;
         idx_ff         <= idx_in;
         npix_ff        <= npix_in;
         carry_bytes_ff <= carry_bytes_in;
         carry_count_ff <= carry_count_in;
         pixel_count_ff <= pixel_count_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      pixel_count_ff <= TOTAL_C)
      else $error("pixel count ran past the frame size");

   a_carry_bound: assert property (@(posedge clock) disable iff (reset)
      carry_count_ff != 2'd3)
      else $error("more than two bytes carried");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff < npix_ff) && (npix_ff == 2'd2 || npix_ff == 2'd3))
      else $error("pixel index outside the word");

endmodule

@@ design/bumq_queue.sv @@
// Short job queue between front and back ends.
module bumq_queue import bumq_pkg::*; #(
   parameter int DEPTH = BUMQ_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  bumq_job_type in_job,
   output logic         out_valid,
   input  logic         out_ready,
   output bumq_job_type out_job
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   bumq_job_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push, pop;

   always_comb begin
      in_ready  = (cnt_ff != FULL_CNT);
      out_valid = (cnt_ff != '0);
      out_job   = slot_ff[rd_ptr_ff];
      push      = in_valid && in_ready;
      pop       = out_valid && out_ready;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_job;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("queue fill above depth");

endmodule

@@ design/bumq_back.sv @@
// Back end: two-stage mean subtract, scale, round and saturate per pixel.
module bumq_back import bumq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  bumq_cfg_type cfg,
   input  logic         job_valid,
   output logic         job_ready,
   input  bumq_job_type job,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [23:0]  rsp_pixel,
   output logic         rsp_last,
   output logic         rsp_frame_end
);

   // Sign and magnitude of (byte << 8) - mean
   function automatic logic [17:0] sub_mean(input logic [7:0] byte_val, input logic [15:0] mean);
      logic [17:0] d;
      logic [16:0] m;
      begin
         d = {2'b00, byte_val, 8'd0} - {2'b00, mean};
         m = d[17] ? 17'(-d) : d[16:0];
         sub_mean = {d[17], m};
      end
   endfunction

   // Scale to the output fraction position and saturate to int8
   function automatic logic [7:0] scale_sat(input logic sgn, input logic [16:0] mag,
                                            input logic [3:0] fix);
      logic [23:0] m;
      logic [17:0] rnd;
      logic [3:0]  sh;
      begin
         sh  = 4'd8 - fix;
         rnd = {1'b0, mag} + (18'd1 << (sh - 4'd1));
         if (fix[3]) begin
            m = {7'd0, mag} << fix[2:0];
         end else begin
            m = {6'd0, rnd >> sh};
         end
         if (sgn) begin
            scale_sat = (m >= 24'd128) ? 8'h80 : 8'(-m[7:0]);
         end else begin
            scale_sat = (m > 24'd127) ? 8'h7f : m[7:0];
         end
      end
   endfunction

   logic        a_valid_ff, a_valid_in;
   logic [17:0] a_blue_ff, a_green_ff, a_red_ff;
   logic        a_last_ff, a_fend_ff;
   logic        out_valid_ff, out_valid_in;
   logic [23:0] out_pixel_ff;
   logic        out_last_ff, out_fend_ff;
   logic        b_adv, a_adv;

   always_comb begin
      b_adv        = !out_valid_ff || rsp_ready;
      a_adv        = !a_valid_ff || b_adv;
      job_ready    = a_adv;
      a_valid_in   = a_adv ? job_valid : a_valid_ff;
      out_valid_in = b_adv ? a_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         a_blue_ff  <= sub_mean(job.blue, cfg.mean_blue);
         a_green_ff <= sub_mean(job.green, cfg.mean_green);
         a_red_ff   <= sub_mean(job.red, cfg.mean_red);
         a_last_ff  <= job.last_in_run;
         a_fend_ff  <= job.frame_end;
      end
      if (b_adv) begin
         out_pixel_ff <= {scale_sat(a_red_ff[17], a_red_ff[16:0], cfg.fix_position),
                          scale_sat(a_green_ff[17], a_green_ff[16:0], cfg.fix_position),
                          scale_sat(a_blue_ff[17], a_blue_ff[16:0], cfg.fix_position)};
         out_last_ff  <= a_last_ff;
         out_fend_ff  <= a_fend_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel     = out_pixel_ff;
   assign rsp_last      = out_last_ff;
   assign rsp_frame_end = out_fend_ff;

endmodule

@@ design/bgr_unpack_mean_quantize_int8.sv @@
// Top level: BGR byte stream unpack, per-channel mean subtract and int8 quantize.
// Path: a pixel is registered in the front word buffer, a queue slot and the two back stages before rsp.
// Throughput: one pixel per cycle while the result channel takes them; a word yields two or three pixels
//   (fewer at the frame end), set by the front end issuing one pixel job per cycle into the queue.
// Reset (synchronous, active high): registers return to their defaults, carry and pixel count
//   clear, queue and back pipeline empty. No clearing pass; the block is ready the cycle after.
module bgr_unpack_mean_quantize_int8 import bumq_pkg::*; #(
   parameter int BUILD_WIDTH  = BUMQ_BUILD_WIDTH,
   parameter int BUILD_HEIGHT = BUMQ_BUILD_HEIGHT,
   parameter int QUEUE_DEPTH  = BUMQ_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] packed_word
   input  logic        req_tuser,   // [0] frame_start
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [23:0] quant_pixel
   output logic        rsp_tlast,   // last_in_run
   output logic        rsp_tuser,   // [0] frame_end
   // register write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   bumq_cfg_type cfg_ff, cfg_in;
   logic         job_valid, job_ready, deq_valid, deq_ready;
   bumq_job_type job, deq_job;

   // Register file: writes land at once; unused indexes fall through and are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FIX_POSITION: cfg_in.fix_position = csr_wdata[3:0];
            CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_wdata[11:0];
            CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_wdata[11:0];
            CSR_MEAN_BLUE:    cfg_in.mean_blue    = csr_wdata;
            CSR_MEAN_GREEN:   cfg_in.mean_green   = csr_wdata;
            CSR_MEAN_RED:     cfg_in.mean_red     = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fix_position <= RST_FIX_POSITION;
         cfg_ff.frame_width  <= RST_FRAME_WIDTH;
         cfg_ff.frame_height <= RST_FRAME_HEIGHT;
         cfg_ff.mean_blue    <= RST_MEAN_BLUE;
         cfg_ff.mean_green   <= RST_MEAN_GREEN;
         cfg_ff.mean_red     <= RST_MEAN_RED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: merge carried bytes with the new word, hold it and issue its pixels in turn
   bumq_front #(
      .BUILD_WIDTH  (BUILD_WIDTH),
      .BUILD_HEIGHT (BUILD_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_word        (req_tdata),
      .req_frame_start (req_tuser),
      .job_valid       (job_valid),
      .job_ready       (job_ready),
      .job             (job)
   );

   // Queue: decouple the front from a stalled result channel
   bumq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (job_valid),
      .in_ready  (job_ready),
      .in_job    (job),
      .out_valid (deq_valid),
      .out_ready (deq_ready),
      .out_job   (deq_job)
   );

   // Back: quantize each pixel and hold it in the output register until taken
   bumq_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .job_valid     (deq_valid),
      .job_ready     (deq_ready),
      .job           (deq_job),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_pixel     (rsp_tdata),
      .rsp_last      (rsp_tlast),
      .rsp_frame_end (rsp_tuser)
   );

endmodule

@@ verif/bgr_unpack_mean_quantize_int8_tb.sv @@
// Self-checking testbench for the BGR unpack, mean subtract and int8 quantise block.
module bgr_unpack_mean_quantize_int8_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bumq_pkg::*;

   // Frame geometry as built
   localparam int FRAME_PIXELS    = BUMQ_BUILD_WIDTH * BUMQ_BUILD_HEIGHT;

   // int8 saturation bounds
   localparam int INT8_MAX = 127;
   localparam int INT8_MIN = -128;

   // Register indexes the block does not decode; writes there must be ignored
   localparam logic [2:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [2:0] CSR_UNUSED_HI = 3'd7;

   // Allow margin for the pipeline to run dry before touching registers
   localparam int DRAIN_CYCLES    = 8;
   localparam int LONG_HOLD       = 48;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PHASE_REQUESTS  = 18;
   localparam int RANDOM_PHASES   = 11;
   localparam int FINAL_REQUESTS  = 24;

   // One expected pixel on the result channel
   typedef struct packed {
      logic [23:0] quant_pixel;
      logic        last_in_run;
      logic        frame_end;
   } pixel_type;

   // Predicts the pixels each request yields and checks them in order
   class quant_scoreboard;
      logic [3:0]  fix_position;
      logic [11:0] frame_width;
      logic [11:0] frame_height;
      logic [15:0] mean_blue;
      logic [15:0] mean_green;
      logic [15:0] mean_red;
      logic [15:0] carry_bytes;
      int          carry_count;
      int          pixel_count;
      pixel_type   pending_pixels[$];
      int          error_count;

      function new();
         fix_position = RST_FIX_POSITION;
         frame_width  = RST_FRAME_WIDTH;
         frame_height = RST_FRAME_HEIGHT;
         mean_blue    = RST_MEAN_BLUE;
         mean_green   = RST_MEAN_GREEN;
         mean_red     = RST_MEAN_RED;
         carry_bytes  = '0;
         carry_count  = 0;
         pixel_count  = 0;
         error_count  = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [15:0] value);
         case (index)
            CSR_FIX_POSITION: fix_position = value[3:0];
            CSR_FRAME_WIDTH:  frame_width  = value[11:0];
            CSR_FRAME_HEIGHT: frame_height = value[11:0];
            CSR_MEAN_BLUE:    mean_blue    = value;
            CSR_MEAN_GREEN:   mean_green   = value;
            CSR_MEAN_RED:     mean_red     = value;
            default: ;
         endcase
      endfunction

      // Subtract the Q8 mean, move to the output fraction, saturate to int8
      function logic [7:0] quantise(logic [7:0] sample, logic [15:0] mean);
         int delta;
         int scaled;
         int sh;
         int half;
         delta = int'(sample) * 256 - int'(mean);
         if (fix_position >= 4'd8) begin
            scaled = delta * (1 << (fix_position - 4'd8));
         end else begin
            sh   = 8 - int'(fix_position);
            half = 1 << (sh - 1);
            if (delta >= 0) scaled = (delta + half) >>> sh;
            else scaled = -((half - delta) >>> sh);
         end
         if (scaled > INT8_MAX) scaled = INT8_MAX;
         else if (scaled < INT8_MIN) scaled = INT8_MIN;
         return scaled[7:0];
      endfunction

      function void absorb_word(logic [63:0] word, logic frame_start);
         logic [7:0] stream[10];
         int         n;
         int         npix;
         int         used;
         pixel_type  px;
         if (frame_start) begin
            carry_bytes = '0;
            carry_count = 0;
            pixel_count = 0;
         end
         if (frame_width != BUMQ_BUILD_WIDTH || frame_height != BUMQ_BUILD_HEIGHT) return;
         if (pixel_count >= FRAME_PIXELS) return;
         n = 0;
         for (int i = 0; i < carry_count; i++) begin
            stream[n] = carry_bytes[8*i +: 8];
            n = n + 1;
         end
         for (int i = 0; i < 8; i++) begin
            stream[n] = word[8*i +: 8];
            n = n + 1;
         end
         npix        = n / 3;
         used        = npix * 3;
         carry_count = n - used;
         carry_bytes = '0;
         for (int i = 0; i < carry_count; i++) carry_bytes[8*i +: 8] = stream[used + i];
         for (int i = 0; i < npix && pixel_count < FRAME_PIXELS; i++) begin
            pixel_count    = pixel_count + 1;
            px.quant_pixel = {quantise(stream[3*i + 2], mean_red),
                              quantise(stream[3*i + 1], mean_green),
                              quantise(stream[3*i], mean_blue)};
            px.frame_end   = (pixel_count == FRAME_PIXELS);
            // the frame end cuts the word short, so it also closes the run
            px.last_in_run = (i == npix - 1) || px.frame_end;
            pending_pixels.push_back(px);
         end
      endfunction

      function void check_pixel(logic [23:0] pixel, logic last_in_run, logic frame_end);
         pixel_type want;
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel %h with no expectation waiting", pixel);
            error_count++;
            return;
         end
         want = pending_pixels.pop_front();
         if (pixel !== want.quant_pixel) begin
            $error("quant_pixel: expected %h, actual %h", want.quant_pixel, pixel);
            error_count++;
         end
         if (last_in_run !== want.last_in_run) begin
            $error("last_in_run: expected %b, actual %b", want.last_in_run, last_in_run);
            error_count++;
         end
         if (frame_end !== want.frame_end) begin
            $error("frame_end: expected %b, actual %b", want.frame_end, frame_end);
            error_count++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;

   quant_scoreboard board = new();
   bit  idle_on        = 1'b0;   // random bursts of idling on both sides
   bit  hold_requested = 1'b0;   // receiver to hold off once, as set by LONG_HOLD
   int  stalled_cycles = 0;      // cycles since the last handshake on either side

   bgr_unpack_mean_quantize_int8 DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Sample both channels at the edge; outputs still hold their pre-edge values here
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.absorb_word(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) board.check_pixel(rsp_tdata, rsp_tlast, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stalled_cycles <= 0;
         else stalled_cycles <= stalled_cycles + 1;
      end
   end

   // Give up when neither side moves for far longer than any legitimate stall
   initial begin : watchdog
      while (stalled_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("** bgr_unpack_mean_quantize_int8: FAILED **");
      $finish;
   end

   // Result side: accept by default, idle in short bursts, or hold off long on request
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_requested) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_requested = 1'b0;
            rsp_tready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one request and hold it until the block takes it
   task automatic send_word(input logic [63:0] word, input logic frame_start);
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= frame_start;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stream random words; open a frame on the first if asked, restart now and then
   task automatic send_random(input int count, input bit open_frame, input int restart_odds);
      logic fs;
      for (int k = 0; k < count; k++) begin
         if (k == 0) fs = open_frame;
         else fs = (restart_odds > 0) && ($urandom_range(1, restart_odds) == 1);
         send_word({$urandom, $urandom}, fs);
         if (idle_on && $urandom_range(0, 4) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
   endtask

   // Drop valid, wait for every expected pixel, then let the pipeline run dry
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register while idle; update the prediction at the same edge
   task automatic write_csr(input logic [2:0] index, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      board.write_reg(index, value);
      @(posedge clock);
   endtask

   task automatic set_means(input logic [15:0] blue, input logic [15:0] green,
                            input logic [15:0] red);
      write_csr(CSR_MEAN_BLUE, blue);
      write_csr(CSR_MEAN_GREEN, green);
      write_csr(CSR_MEAN_RED, red);
   endtask

   task automatic set_frame(input logic [11:0] width, input logic [11:0] height);
      write_csr(CSR_FRAME_WIDTH, {4'd0, width});
      write_csr(CSR_FRAME_HEIGHT, {4'd0, height});
   endtask

   initial begin : stimulus
      logic [15:0] mb;
      logic [15:0] mg;
      logic [15:0] mr;
      logic [3:0]  fix;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: byte extremes and mid-scale patterns
      send_word(64'h0000_0000_0000_0000, 1'b1);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_word(64'h8080_8080_8080_8080, 1'b0);
      send_word(64'h7F7F_7F7F_7F7F_7F7F, 1'b0);
      send_word(64'h0123_4567_89AB_CDEF, 1'b0);
      settle();

      // Widest right shift with extreme means: drive both saturation rails
      write_csr(CSR_FIX_POSITION, 16'd0);
      set_means(16'h0000, 16'hFFFF, 16'h0001);
      send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_word(64'h0000_0000_0000_0000, 1'b0);
      send_word(64'h00FF_00FF_00FF_00FF, 1'b0);
      settle();

      // Left shift at its largest: small deltas either side of zero still saturate
      write_csr(CSR_FIX_POSITION, 16'd15);
      set_means(16'h0080, 16'h7F00, 16'h8000);
      send_word(64'h7F80_7F80_007F_8001, 1'b0);
      send_word(64'h8180_7E7F_8081_7F7F, 1'b0);
      settle();

      // No shift at all: the delta passes straight to saturation
      write_csr(CSR_FIX_POSITION, 16'd8);
      send_word(64'h8081_7F80_7E82_7F80, 1'b0);
      settle();

      // Odd means put deltas exactly half way: round away from zero both signs
      write_csr(CSR_FIX_POSITION, 16'd7);
      set_means(16'h0001, 16'h00FF, 16'h0081);
      send_word(64'h0001_0000_0100_0001, 1'b1);
      send_word({$urandom, $urandom}, 1'b0);
      settle();
      write_csr(CSR_FIX_POSITION, 16'd1);
      set_means(16'h0040, 16'hFFC0, 16'h7FC0);
      send_word(64'h7F00_FF00_007F_FF00, 1'b1);
      settle();

      // Declared size differs from the build: nothing comes out, carry is held
      set_frame(12'd223, 12'd224);
      send_word({$urandom, $urandom}, 1'b0);
      send_word({$urandom, $urandom}, 1'b0);
      settle();
      set_frame(12'd0, 12'd224);
      send_word({$urandom, $urandom}, 1'b0);
      settle();
      set_frame(12'd4095, 12'd0);
      send_word({$urandom, $urandom}, 1'b0);
      settle();
      // frame start still clears carry and count while the size is wrong
      set_frame(12'd224, 12'd4095);
      send_word({$urandom, $urandom}, 1'b1);
      settle();
      set_frame(12'd224, 12'd224);
      send_word({$urandom, $urandom}, 1'b0);
      settle();

      // Writes to undecoded indexes must leave every register alone
      write_csr(CSR_UNUSED_LO, 16'hFFFF);
      write_csr(CSR_UNUSED_HI, 16'hFFFF);
      send_word({$urandom, $urandom}, 1'b0);
      settle();

      // Random phases, each with its own settings; one phase runs at a wrong size
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0: fix = 4'd0;
            1: fix = 4'd15;
            2: fix = 4'd8;
            default: fix = 4'($urandom_range(0, 15));
         endcase
         if (phase == 1) begin
            mb = 16'hFFFF; mg = 16'hFFFF; mr = 16'hFFFF;
         end else if (phase == 2) begin
            mb = 16'h0000; mg = 16'h0000; mr = 16'h0000;
         end else begin
            mb = 16'($urandom); mg = 16'($urandom); mr = 16'($urandom);
         end
         write_csr(CSR_FIX_POSITION, {12'd0, fix});
         set_means(mb, mg, mr);
         if (phase == 6) set_frame(12'($urandom_range(0, 223)), 12'($urandom_range(225, 4095)));
         else set_frame(12'd224, 12'd224);

         // phase 4: sender streams flat out while the receiver holds off, filling the queue
         idle_on = (phase % 3 != 2) && (phase != 4);
         if (phase == 4) hold_requested = 1'b1;
         send_random(PHASE_REQUESTS, 1'($urandom_range(0, 1)), 12);
         settle();
      end

      // Final stretch without idling: open a frame and stream flat out
      idle_on = 1'b0;
      write_csr(CSR_FIX_POSITION, 16'($urandom_range(0, 15)));
      set_means(16'($urandom), 16'($urandom), 16'($urandom));
      set_frame(12'd224, 12'd224);
      send_random(FINAL_REQUESTS, 1'b1, 0);
      settle();
      // a new frame start clears the carry and restarts the count
      send_random(4, 1'b1, 0);
      settle();

      if (board.error_count == 0) begin
         $display("** bgr_unpack_mean_quantize_int8: PASSED **");
      end else begin
         $display("** bgr_unpack_mean_quantize_int8: FAILED **");
      end
      $finish;
   end

endmodule

@@ bgr_unpack_mean_quantize_int8.f @@
design/bumq_pkg.sv
design/bumq_front.sv
design/bumq_queue.sv
design/bumq_back.sv
design/bgr_unpack_mean_quantize_int8.sv
verif/bgr_unpack_mean_quantize_int8_tb.sv
